// ----- rtl/ioirc_pkg.sv -----
// ioirc_pkg: shared types, codes and constants of the io interrupt redirection controller
// no dependencies
package ioirc_pkg;

  localparam int PIN_COUNT_DEF   = 32;
  localparam int COUNT_WIDTH_DEF = 16;

  localparam logic [63:0] ENTRY_RESET = 64'h0001_0000_0001_0000;
  localparam int BIT_MASKED  = 16;
  localparam int BIT_LEVEL   = 15;
  localparam int BIT_RIRR    = 14;
  localparam int BIT_DELIVS  = 12;
  localparam int BIT_LOGICAL = 11;
  localparam logic [7:0] TABLE_BASE = 8'h10;
  localparam logic [7:0] VERSION_LO = 8'h11;
  localparam logic [11:0] OFF_SELECT = 12'h000;
  localparam logic [11:0] OFF_WINDOW = 12'h010;
  localparam logic [3:0]  ACCESS_WORD = 4'd4;

  localparam logic [7:0] IDX_ID   = 8'h00;
  localparam logic [7:0] IDX_VER  = 8'h01;
  localparam logic [7:0] IDX_ARB  = 8'h02;

  typedef enum logic [2:0] {
    OP_READ     = 3'd0,
    OP_WRITE    = 3'd1,
    OP_ASSERT   = 3'd2,
    OP_DEASSERT = 3'd3,
    OP_PULSE    = 3'd4,
    OP_EOI      = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BADPIN  = 2'd1,
    ST_SAT_HI  = 2'd2,
    ST_SAT_LO  = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_RD_WAIT,
    S_RD_DONE,
    S_WR_MERGE,
    S_PIN_UP,
    S_PIN_DOWN,
    S_SEND,
    S_EOI_READ,
    S_EOI_CHECK,
    S_FINISH
  } state_t;

endpackage

// ----- rtl/ioirc_ram.sv -----
// ioirc_ram: generic single-port write, single-port read ram with registered read
// no dependencies
module ioirc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/io_interrupt_redirection_controller_unit.sv -----
// io_interrupt_redirection_controller_unit: top level, sequencer over the entry and count rams
// depends on ioirc_pkg and ioirc_ram
//
// an eoi visits every pin in turn; the last result comes in the final busy cycle.
// throughput: one item at a time, the next is taken in the cycle after the last result.
// reset: rst is synchronous; valid bits stand in for the reset values of the
// table and the counts, so the block takes items in the cycle after reset.
// results come one per strobe cycle; the receiver cannot stall them.
module io_interrupt_redirection_controller_unit #(
  parameter int PIN_COUNT   = ioirc_pkg::PIN_COUNT_DEF,
  parameter int COUNT_WIDTH = ioirc_pkg::COUNT_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  operation,
  input  logic [11:0] bus_offset,
  input  logic [3:0]  access_size,
  input  logic [31:0] write_data,
  input  logic [5:0]  irq_line,
  input  logic [7:0]  eoi_vector,
  output logic        strobe,
  output logic        has_delivery,
  output logic        level_trigger,
  output logic [7:0]  dest_id,
  output logic        physical_dest,
  output logic [2:0]  delivery_mode,
  output logic [7:0]  int_vector,
  output logic [31:0] read_data,
  output logic [1:0]  status,
  output logic        last
);

  localparam int PW = (PIN_COUNT > 1) ? $clog2(PIN_COUNT) : 1;
  localparam logic [COUNT_WIDTH-1:0] CMAX = {COUNT_WIDTH{1'b1}};
  localparam logic [COUNT_WIDTH-1:0] CONE = COUNT_WIDTH'(1);
  localparam logic [PW-1:0] PLAST = PW'(PIN_COUNT - 1);

  ioirc_pkg::state_t state, state_next;

  logic [2:0]  op;
  logic [11:0] off;
  logic [3:0]  size;
  logic [31:0] wd;
  logic [5:0]  line;
  logic [7:0]  vec;
  logic [31:0] rsel, rsel_next;
  logic [31:0] cid, cid_next;
  logic [31:0] rd, rd_next;
  logic [1:0]  st, st_next;
  logic [PW-1:0] pin, pin_next;
  logic        pend, pend_next;
  logic [63:0] pend_e, pend_e_next;
  logic        sent, sent_next;
  logic [63:0] hold_e, hold_e_next;
  logic        pulse2, pulse2_next;
  logic        eoi_mode, eoi_mode_next;
  logic [PIN_COUNT-1:0] tvalid, tvalid_next;
  logic [PIN_COUNT-1:0] cvalid, cvalid_next;

  logic        t_we;
  logic [63:0] t_wdata, t_rdata, entry;
  logic        c_we;
  logic [COUNT_WIDTH-1:0] c_wdata, c_rdata, cnt;
  logic [PW-1:0] raddr;

  ioirc_ram #(.WIDTH(64), .DEPTH(PIN_COUNT)) u_table (
    .clk(clk), .we(t_we), .waddr(pin), .wdata(t_wdata), .raddr(raddr), .rdata(t_rdata)
  );
  ioirc_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(PIN_COUNT)) u_count (
    .clk(clk), .we(c_we), .waddr(pin), .wdata(c_wdata), .raddr(raddr), .rdata(c_rdata)
  );

  assign entry = tvalid[pin] ? t_rdata : ioirc_pkg::ENTRY_RESET;
  assign cnt   = cvalid[pin] ? c_rdata : '0;

  logic [7:0] idx;
  logic       idx_tab;
  logic [7:0] idx_rel;
  logic [63:0] wmask, merged;
  assign idx     = rsel[7:0];
  assign idx_rel = idx - ioirc_pkg::TABLE_BASE;
  assign idx_tab = (idx >= ioirc_pkg::TABLE_BASE) &&
                   ({1'b0, idx_rel} < 9'(2 * PIN_COUNT));

  always_comb begin
    wmask = idx_rel[0] ? {32'hffff_ffff, 32'h0} : {32'h0, 32'hffff_ffff};
    wmask[ioirc_pkg::BIT_RIRR]   = 1'b0;
    wmask[ioirc_pkg::BIT_DELIVS] = 1'b0;
    merged = (entry & ~wmask) | ({wd, wd} & wmask);
    if (!merged[ioirc_pkg::BIT_LEVEL]) merged[ioirc_pkg::BIT_RIRR] = 1'b0;
  end

  logic access_ok;
  assign access_ok = (size == ioirc_pkg::ACCESS_WORD) &&
                     (off == ioirc_pkg::OFF_SELECT || off == ioirc_pkg::OFF_WINDOW);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ioirc_pkg::S_IDLE;
      rsel   <= '0;
      cid    <= '0;
      tvalid <= '0;
      cvalid <= '0;
    end else begin
      state  <= state_next;
      rsel   <= rsel_next;
      cid    <= cid_next;
      tvalid <= tvalid_next;
      cvalid <= cvalid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ioirc_pkg::S_IDLE && start) begin
      op <= operation; off <= bus_offset; size <= access_size;
      wd <= write_data; line <= irq_line; vec <= eoi_vector;
    end
    rd <= rd_next; st <= st_next; pin <= pin_next; pend <= pend_next;
    pend_e <= pend_e_next; sent <= sent_next; hold_e <= hold_e_next;
    pulse2 <= pulse2_next; eoi_mode <= eoi_mode_next;
  end

  always_comb begin
    state_next = state;
    rsel_next = rsel; cid_next = cid; tvalid_next = tvalid; cvalid_next = cvalid;
    rd_next = rd; st_next = st; pin_next = pin; pend_next = pend; pend_e_next = pend_e;
    sent_next = sent; hold_e_next = hold_e; pulse2_next = pulse2; eoi_mode_next = eoi_mode;
    raddr = pin;
    t_we = 1'b0; t_wdata = entry;
    c_we = 1'b0; c_wdata = cnt;
    strobe = 1'b0; has_delivery = 1'b0; level_trigger = 1'b0; dest_id = '0;
    physical_dest = 1'b0; delivery_mode = '0; int_vector = '0; last = 1'b0;
    read_data = rd; status = st;
    busy = (state != ioirc_pkg::S_IDLE);
    unique case (state)
      ioirc_pkg::S_IDLE: begin
        if (start) begin
          state_next = ioirc_pkg::S_DECODE;
          rd_next = '0; st_next = ioirc_pkg::ST_OK; sent_next = 1'b0;
          pend_next = 1'b0; eoi_mode_next = 1'b0; pulse2_next = 1'b0;
          pin_next = '0;
        end
      end
      ioirc_pkg::S_DECODE: begin
        state_next = ioirc_pkg::S_FINISH;
        case (op) inside
          ioirc_pkg::OP_READ, ioirc_pkg::OP_WRITE: begin
            if (access_ok) begin
              if (off == ioirc_pkg::OFF_SELECT) begin
                if (op == ioirc_pkg::OP_READ) rd_next = rsel;
                else rsel_next = wd;
              end else if (idx_tab) begin
                pin_next = idx_rel[PW:1];
                raddr = idx_rel[PW:1];
                state_next = (op == ioirc_pkg::OP_READ) ? ioirc_pkg::S_RD_DONE
                                                        : ioirc_pkg::S_WR_MERGE;
              end else if (op == ioirc_pkg::OP_READ) begin
                if (idx == ioirc_pkg::IDX_ID || idx == ioirc_pkg::IDX_ARB) rd_next = cid;
                else if (idx == ioirc_pkg::IDX_VER)
                  rd_next = {8'h0, 8'(PIN_COUNT - 1), 8'h0, ioirc_pkg::VERSION_LO};
              end else if (idx == ioirc_pkg::IDX_ID) begin
                cid_next = {wd[31:24], 24'h0};
              end
            end
          end
          ioirc_pkg::OP_ASSERT, ioirc_pkg::OP_DEASSERT, ioirc_pkg::OP_PULSE: begin
            if ({1'b0, line} >= 7'(PIN_COUNT)) begin
              st_next = ioirc_pkg::ST_BADPIN;
            end else begin
              pin_next = PW'(line);
              raddr = PW'(line);
              pulse2_next = (op == ioirc_pkg::OP_PULSE);
              state_next = (op == ioirc_pkg::OP_DEASSERT) ? ioirc_pkg::S_PIN_DOWN
                                                          : ioirc_pkg::S_PIN_UP;
            end
          end
          ioirc_pkg::OP_EOI: begin
            eoi_mode_next = 1'b1;
            raddr = '0;
            state_next = ioirc_pkg::S_EOI_CHECK;
          end
          default: ;
        endcase
      end
      ioirc_pkg::S_RD_DONE: begin
        rd_next = idx_rel[0] ? entry[63:32] : entry[31:0];
        state_next = ioirc_pkg::S_FINISH;
      end
      ioirc_pkg::S_WR_MERGE: begin
        t_we = 1'b1; t_wdata = merged; tvalid_next[pin] = 1'b1;
        pend_e_next = merged;
        pend_next = merged[ioirc_pkg::BIT_LEVEL] && (cnt != '0);
        state_next = ioirc_pkg::S_SEND;
      end
      ioirc_pkg::S_PIN_UP: begin
        pend_e_next = entry;
        if (cnt == CMAX) begin
          st_next = ioirc_pkg::ST_SAT_HI;
          pend_next = 1'b0;
          state_next = ioirc_pkg::S_FINISH;
        end else begin
          // a pulse leaves the count where it was
          if (!pulse2) begin
            c_we = 1'b1; c_wdata = cnt + CONE; cvalid_next[pin] = 1'b1;
          end
          pulse2_next = 1'b0;
          pend_next = (cnt == '0);
          state_next = ioirc_pkg::S_SEND;
        end
      end
      ioirc_pkg::S_PIN_DOWN: begin
        pend_e_next = entry;
        pulse2_next = 1'b0;
        if (cnt == '0) begin
          st_next = ioirc_pkg::ST_SAT_LO;
          pend_next = 1'b0;
          state_next = ioirc_pkg::S_FINISH;
        end else begin
          c_we = 1'b1; c_wdata = cnt - CONE; cvalid_next[pin] = 1'b1;
          pend_next = 1'b0;
          state_next = ioirc_pkg::S_FINISH;
        end
      end
      ioirc_pkg::S_SEND: begin
        state_next = ioirc_pkg::S_FINISH;
        if (eoi_mode && pin != PLAST) state_next = ioirc_pkg::S_EOI_READ;
        if (pend && !pend_e[ioirc_pkg::BIT_MASKED] &&
            !(pend_e[ioirc_pkg::BIT_LEVEL] && pend_e[ioirc_pkg::BIT_RIRR])) begin
          if (pend_e[ioirc_pkg::BIT_LEVEL]) begin
            t_we = 1'b1; tvalid_next[pin] = 1'b1;
            t_wdata = pend_e;
            t_wdata[ioirc_pkg::BIT_RIRR] = 1'b1;
          end
          // the held delivery goes out, the new one waits for the next or the end
          strobe = sent;
          sent_next = 1'b1;
          hold_e_next = pend_e;
        end
        raddr = pin + PW'(1);
        if (eoi_mode) pin_next = pin + PW'(1);
      end
      ioirc_pkg::S_EOI_READ: begin
        state_next = ioirc_pkg::S_EOI_CHECK;
      end
      ioirc_pkg::S_EOI_CHECK: begin
        pend_next = 1'b0;
        pend_e_next = entry;
        if (entry[ioirc_pkg::BIT_RIRR] && entry[7:0] == vec) begin
          t_we = 1'b1; tvalid_next[pin] = 1'b1;
          t_wdata = entry; t_wdata[ioirc_pkg::BIT_RIRR] = 1'b0;
          pend_e_next[ioirc_pkg::BIT_RIRR] = 1'b0;
          pend_next = (cnt != '0);
        end
        state_next = ioirc_pkg::S_SEND;
      end
      ioirc_pkg::S_FINISH: begin
        strobe = 1'b1; last = 1'b1;
        state_next = ioirc_pkg::S_IDLE;
      end
      default: state_next = ioirc_pkg::S_IDLE;
    endcase
    if (strobe && sent) begin
      has_delivery = 1'b1;
      level_trigger = hold_e[ioirc_pkg::BIT_LEVEL];
      dest_id = hold_e[63:56];
      physical_dest = ~hold_e[ioirc_pkg::BIT_LOGICAL];
      delivery_mode = hold_e[10:8];
      int_vector = hold_e[7:0];
    end
  end

endmodule

// ----- sim/tb_io_interrupt_redirection_controller_unit.sv -----
// tb_io_interrupt_redirection_controller_unit: self-checking bench for the redirection controller
// a behavioral predictor queues the expected deliveries, a directed table and random items drive it
// depends on ioirc_pkg and io_interrupt_redirection_controller_unit
module tb_io_interrupt_redirection_controller_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PINS       = ioirc_pkg::PIN_COUNT_DEF;
  localparam int CNT_MAX    = (1 << ioirc_pkg::COUNT_WIDTH_DEF) - 1;
  localparam int IDLE_LIMIT = 2000;
  localparam logic [31:0] VERSION_WORD = ((PINS - 1) << 16) | int'(ioirc_pkg::VERSION_LO);
  localparam int SEL  = int'(ioirc_pkg::OFF_SELECT);
  localparam int WIN  = int'(ioirc_pkg::OFF_WINDOW);
  localparam int WORD = int'(ioirc_pkg::ACCESS_WORD);
  localparam int OP_SPARE_A = 6;
  localparam int OP_SPARE_B = 7;

  typedef struct {
    logic [2:0]  op;
    logic [11:0] off;
    logic [3:0]  size;
    logic [31:0] wd;
    logic [5:0]  line;
    logic [7:0]  vec;
    bit          typed;
    logic [31:0] t_rd;
    ioirc_pkg::status_t t_st;
  } bus_item_t;

  typedef struct packed {
    logic        del;
    logic        lvl;
    logic [7:0]  dest;
    logic        phys;
    logic [2:0]  dmode;
    logic [7:0]  vec;
    logic [31:0] rd;
    logic [1:0]  st;
    logic        fin;
  } delivery_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [2:0]  operation = '0;
  logic [11:0] bus_offset = '0;
  logic [3:0]  access_size = '0;
  logic [31:0] write_data = '0;
  logic [5:0]  irq_line = '0;
  logic [7:0]  eoi_vector = '0;
  logic strobe, has_delivery, level_trigger, physical_dest, last;
  logic [7:0]  dest_id, int_vector;
  logic [2:0]  delivery_mode;
  logic [31:0] read_data;
  logic [1:0]  status;

  io_interrupt_redirection_controller_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .operation(operation), .bus_offset(bus_offset), .access_size(access_size),
    .write_data(write_data), .irq_line(irq_line), .eoi_vector(eoi_vector),
    .strobe(strobe), .has_delivery(has_delivery), .level_trigger(level_trigger),
    .dest_id(dest_id), .physical_dest(physical_dest), .delivery_mode(delivery_mode),
    .int_vector(int_vector), .read_data(read_data), .status(status), .last(last)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [63:0] redir_tbl [PINS];
  int unsigned pin_cnt [PINS];
  logic [31:0] sel_reg, id_reg;
  delivery_t   item_out [$];
  delivery_t   pending [$];

  int errors = 0;
  int idle_cycles = 0;

  task automatic fire(int p);
    logic [63:0] e;
    delivery_t d;
    e = redir_tbl[p];
    if (e[ioirc_pkg::BIT_MASKED]) return;
    if (e[ioirc_pkg::BIT_LEVEL]) begin
      if (e[ioirc_pkg::BIT_RIRR]) return;
      redir_tbl[p][ioirc_pkg::BIT_RIRR] = 1'b1;
    end
    if (item_out.size() < PINS) begin
      d = '{1'b1, e[ioirc_pkg::BIT_LEVEL], e[63:56], ~e[ioirc_pkg::BIT_LOGICAL], e[10:8],
            e[7:0], '0, '0, 1'b0};
      item_out.push_back(d);
    end
  endtask

  task automatic move_pin(int p, bit up, output logic [1:0] st);
    int unsigned oldc;
    oldc = pin_cnt[p];
    st = ioirc_pkg::ST_OK;
    if (up) begin
      if (pin_cnt[p] != CNT_MAX) pin_cnt[p]++; else st = ioirc_pkg::ST_SAT_HI;
    end else begin
      if (pin_cnt[p] != 0) pin_cnt[p]--; else st = ioirc_pkg::ST_SAT_LO;
    end
    if (oldc == 0 && pin_cnt[p] == 1) fire(p);
  endtask

  task automatic predict(bus_item_t it);
    logic [31:0] rd;
    logic [1:0]  st;
    logic [7:0]  idx;
    logic [63:0] e, m, ro;
    int p;
    delivery_t d;
    rd = '0;
    st = ioirc_pkg::ST_OK;
    item_out.delete();
    idx = sel_reg[7:0];
    p = (idx - ioirc_pkg::TABLE_BASE) >> 1;
    ro = 64'h0;
    ro[ioirc_pkg::BIT_RIRR] = 1'b1;
    ro[ioirc_pkg::BIT_DELIVS] = 1'b1;
    if ((it.op == ioirc_pkg::OP_READ || it.op == ioirc_pkg::OP_WRITE) &&
        it.size == ioirc_pkg::ACCESS_WORD &&
        (it.off == ioirc_pkg::OFF_SELECT || it.off == ioirc_pkg::OFF_WINDOW)) begin
      if (it.off == ioirc_pkg::OFF_SELECT) begin
        if (it.op == ioirc_pkg::OP_READ) rd = sel_reg; else sel_reg = it.wd;
      end else if (it.op == ioirc_pkg::OP_READ) begin
        if (idx == ioirc_pkg::IDX_ID || idx == ioirc_pkg::IDX_ARB) rd = id_reg;
        else if (idx == ioirc_pkg::IDX_VER) rd = VERSION_WORD;
        else if (idx >= ioirc_pkg::TABLE_BASE && idx < ioirc_pkg::TABLE_BASE + 2 * PINS)
          rd = idx[0] ? redir_tbl[p][63:32] : redir_tbl[p][31:0];
      end else begin
        if (idx == ioirc_pkg::IDX_ID) id_reg = {it.wd[31:24], 24'h0};
        if (idx >= ioirc_pkg::TABLE_BASE && idx < ioirc_pkg::TABLE_BASE + 2 * PINS) begin
          m = idx[0] ? {32'hffffffff, 32'h0} : {32'h0, 32'hffffffff};
          e = redir_tbl[p];
          e &= ~m | ro;
          e |= (idx[0] ? {it.wd, 32'h0} : {32'h0, it.wd}) & m & ~ro;
          if (!e[ioirc_pkg::BIT_LEVEL]) e[ioirc_pkg::BIT_RIRR] = 1'b0;
          redir_tbl[p] = e;
          if (e[ioirc_pkg::BIT_LEVEL] && pin_cnt[p] > 0) fire(p);
        end
      end
    end else if (it.op == ioirc_pkg::OP_ASSERT || it.op == ioirc_pkg::OP_DEASSERT ||
                 it.op == ioirc_pkg::OP_PULSE) begin
      if (it.line >= PINS) st = ioirc_pkg::ST_BADPIN;
      else if (it.op == ioirc_pkg::OP_ASSERT) move_pin(it.line, 1'b1, st);
      else if (it.op == ioirc_pkg::OP_DEASSERT) move_pin(it.line, 1'b0, st);
      else begin
        move_pin(it.line, 1'b1, st);
        if (st == ioirc_pkg::ST_OK) move_pin(it.line, 1'b0, st);
      end
    end else if (it.op == ioirc_pkg::OP_EOI) begin
      for (int q = 0; q < PINS; q++) begin
        if (redir_tbl[q][ioirc_pkg::BIT_RIRR] && redir_tbl[q][7:0] == it.vec) begin
          redir_tbl[q][ioirc_pkg::BIT_RIRR] = 1'b0;
          if (pin_cnt[q] > 0) fire(q);
        end
      end
    end
    if (item_out.size() == 0) begin
      d = '{1'b0, 1'b0, 8'h0, 1'b0, 3'h0, 8'h0, '0, '0, 1'b0};
      item_out.push_back(d);
    end
    if (it.typed) begin
      rd = it.t_rd;
      st = it.t_st;
    end
    foreach (item_out[k]) begin
      item_out[k].rd = rd;
      item_out[k].st = st;
      item_out[k].fin = (k == item_out.size() - 1);
      pending.push_back(item_out[k]);
    end
  endtask

  // leaves start high; the caller lowers it when idling
  task automatic issue(bus_item_t it);
    start <= 1'b1;
    operation <= it.op;
    bus_offset <= it.off;
    access_size <= it.size;
    write_data <= it.wd;
    irq_line <= it.line;
    eoi_vector <= it.vec;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict(it);
  endtask

  task automatic pause(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  function automatic bus_item_t mk(int op, int off, int size, logic [31:0] wd,
                                   int line, int vec);
    bus_item_t it;
    it = '{3'(op), 12'(off), 4'(size), wd, 6'(line), 8'(vec), 1'b0, '0, ioirc_pkg::ST_OK};
    return it;
  endfunction

  function automatic bus_item_t mkt(bus_item_t it, logic [31:0] rd, ioirc_pkg::status_t st);
    it.typed = 1'b1;
    it.t_rd = rd;
    it.t_st = st;
    return it;
  endfunction

  function automatic bus_item_t rand_item();
    bus_item_t it;
    int r;
    logic [31:0] d;
    r = $urandom_range(0, 99);
    it = mk(ioirc_pkg::OP_READ, SEL, WORD, $urandom, $urandom_range(0, 7),
            32 + $urandom_range(0, 3));
    if (r < 15) begin
      it.op = ioirc_pkg::OP_WRITE;
      case ($urandom_range(0, 3))
        0: it.wd = $urandom_range(0, 2);
        1: it.wd = $urandom;
        default: it.wd = 32'(ioirc_pkg::TABLE_BASE) + $urandom_range(0, 15);
      endcase
      if ($urandom_range(0, 9) == 0)
        it.wd = 32'(ioirc_pkg::TABLE_BASE) + $urandom_range(0, 2 * PINS - 1);
    end else if (r < 30) begin
      it.op = ioirc_pkg::OP_WRITE;
      it.off = ioirc_pkg::OFF_WINDOW;
      d = $urandom;
      if ($urandom_range(0, 3) != 0) begin
        d[ioirc_pkg::BIT_MASKED] = 1'b0;
        d[7:0] = 8'(32 + $urandom_range(0, 3));
      end
      it.wd = d;
    end else if (r < 40) begin
      it.off = $urandom_range(0, 1) ? ioirc_pkg::OFF_WINDOW : ioirc_pkg::OFF_SELECT;
    end else if (r < 75) begin
      it.op = 3'(int'(ioirc_pkg::OP_ASSERT) + $urandom_range(0, 2));
      if ($urandom_range(0, 9) == 0) it.line = 6'($urandom_range(0, 63));
    end else if (r < 90) begin
      it.op = ioirc_pkg::OP_EOI;
      if ($urandom_range(0, 7) == 0) it.vec = 8'($urandom_range(0, 255));
    end else begin
      it.op = 3'($urandom_range(0, 7));
      it.off = 12'($urandom_range(0, 4095));
      it.size = 4'($urandom_range(0, 15));
      it.line = 6'($urandom_range(0, 63));
      it.vec = 8'($urandom_range(0, 255));
    end
    return it;
  endfunction

  // result checker
  always @(posedge clk) begin
    delivery_t x;
    delivery_t y;
    if (!rst && strobe) begin
      y = '{has_delivery, level_trigger, dest_id, physical_dest, delivery_mode,
            int_vector, read_data, status, last};
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", y);
      end else begin
        x = pending.pop_front();
        if (x !== y) begin
          errors++;
          if (errors <= 10) $display("mismatch: expected %p actual %p", x, y);
        end
      end
    end
  end

  // watchdog on cycles with no item taken and no result
  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    bus_item_t plan [$];
    int n_rand;
    sel_reg = '0;
    id_reg = '0;
    for (int p = 0; p < PINS; p++) begin
      redir_tbl[p] = ioirc_pkg::ENTRY_RESET;
      pin_cnt[p] = 0;
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    plan.push_back(mkt(mk(ioirc_pkg::OP_READ, SEL, WORD, '0, 0, 0), 32'h0, ioirc_pkg::ST_OK));
    plan.push_back(mk(ioirc_pkg::OP_WRITE, SEL, WORD, 32'(ioirc_pkg::IDX_VER), 0, 0));
    plan.push_back(mkt(mk(ioirc_pkg::OP_READ, WIN, WORD, '0, 0, 0), VERSION_WORD,
                       ioirc_pkg::ST_OK));
    plan.push_back(mk(ioirc_pkg::OP_WRITE, SEL, WORD, 32'(ioirc_pkg::IDX_ID), 0, 0));
    plan.push_back(mk(ioirc_pkg::OP_WRITE, WIN, WORD, 32'hffffffff, 0, 0));
    plan.push_back(mkt(mk(ioirc_pkg::OP_READ, WIN, WORD, '0, 0, 0), 32'hff000000,
                       ioirc_pkg::ST_OK));
    plan.push_back(mkt(mk(ioirc_pkg::OP_READ, WIN, 8, '0, 0, 0), 32'h0, ioirc_pkg::ST_OK));
    plan.push_back(mkt(mk(ioirc_pkg::OP_READ, 12'hfff, WORD, '0, 0, 0), 32'h0,
                       ioirc_pkg::ST_OK));
    plan.push_back(mkt(mk(ioirc_pkg::OP_ASSERT, 0, 0, '0, 32, 0), 32'h0,
                       ioirc_pkg::ST_BADPIN));
    plan.push_back(mkt(mk(ioirc_pkg::OP_PULSE, 0, 0, '0, 63, 0), 32'h0,
                       ioirc_pkg::ST_BADPIN));
    plan.push_back(mkt(mk(ioirc_pkg::OP_DEASSERT, 0, 0, '0, 0, 0), 32'h0,
                       ioirc_pkg::ST_SAT_LO));
    plan.push_back(mk(ioirc_pkg::OP_WRITE, SEL, WORD, 32'(ioirc_pkg::TABLE_BASE), 0, 0));
    plan.push_back(mk(ioirc_pkg::OP_WRITE, WIN, WORD, 32'h0000f320, 0, 0));
    plan.push_back(mk(ioirc_pkg::OP_WRITE, SEL, WORD, 32'(ioirc_pkg::TABLE_BASE) + 1, 0, 0));
    plan.push_back(mk(ioirc_pkg::OP_WRITE, WIN, WORD, 32'hab000000, 0, 0));
    plan.push_back(mk(ioirc_pkg::OP_ASSERT, 0, 0, '0, 0, 0));
    plan.push_back(mk(ioirc_pkg::OP_ASSERT, 0, 0, '0, 0, 0));
    plan.push_back(mk(ioirc_pkg::OP_PULSE, 0, 0, '0, 0, 0));
    plan.push_back(mk(ioirc_pkg::OP_EOI, 0, 0, '0, 0, 32'h20));
    plan.push_back(mk(ioirc_pkg::OP_DEASSERT, 0, 0, '0, 0, 0));
    plan.push_back(mk(ioirc_pkg::OP_EOI, 0, 0, '0, 0, 32'h21));
    plan.push_back(mk(ioirc_pkg::OP_WRITE, SEL, WORD, 32'(ioirc_pkg::TABLE_BASE) + 2, 0, 0));
    plan.push_back(mk(ioirc_pkg::OP_WRITE, WIN, WORD, 32'h00000c22, 0, 0));
    plan.push_back(mk(ioirc_pkg::OP_PULSE, 0, 0, '0, 1, 0));
    plan.push_back(mk(OP_SPARE_A, 0, 0, '0, 0, 0));
    plan.push_back(mk(OP_SPARE_B, 0, 0, '0, 0, 0));
    foreach (plan[i]) issue(plan[i]);

    n_rand = 334;
    for (int i = 0; i < n_rand; i++) begin
      if (i == n_rand / 2) begin
        start <= 1'b0;
        @(posedge clk);
        while (pending.size() != 0) @(posedge clk);
      end else if (i < n_rand - 40 && $urandom_range(0, 3) == 0) begin
        pause($urandom_range(1, 16));
      end
      issue(rand_item());
    end
    start <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
